@@ hw/rtl/dhsa_pkg.sv @@
package dhsa_pkg;

  // Default table depth and fixed field widths.
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int KEY_W           = 31;
  localparam int CFG_W           = 9;
  localparam int SLOT_W          = 8;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 9'd251;

  // Control bits of one access to the occupancy memory.
  typedef struct packed {
    logic rd;
    logic wr;
    logic wdata;
  } mem_cmd_t;

endpackage

@@ hw/rtl/dhsa_mod_unit.sv @@
module dhsa_mod_unit #(
  parameter int MW = 9
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dhsa_pkg::KEY_W-1:0] dividend,
  input  logic [MW-1:0]              divisor,
  output logic                       done,
  output logic [MW-1:0]              rem
);

  localparam int CNT_W = $clog2(dhsa_pkg::KEY_W);

  logic                       run;
  logic [CNT_W-1:0]           cnt;
  logic [dhsa_pkg::KEY_W-1:0] dvd;
  logic [MW-1:0]              dsr;
  logic [MW-1:0]              r;
  logic [MW:0]                trial;
  logic [MW:0]                r_next;

  // Restoring remainder, one dividend bit per cycle from the top.
  always_comb begin
    trial = {r, dvd[dhsa_pkg::KEY_W-1]};
    if (trial >= {1'b0, dsr}) begin
      r_next = trial - {1'b0, dsr};
    end else begin
      r_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        dvd <= dividend;
        dsr <= divisor;
        r   <= '0;
      end else if (run) begin
        r   <= r_next[MW-1:0];
        dvd <= {dvd[dhsa_pkg::KEY_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(dhsa_pkg::KEY_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = r;

endmodule

@@ hw/rtl/dhsa_occ_mem.sv @@
module dhsa_occ_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic               clk,
  input  dhsa_pkg::mem_cmd_t cmd,
  input  logic [AW-1:0]      addr,
  output logic               rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= cmd.wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ hw/rtl/double_hash_slot_allocator_unit.sv @@
// Double-hashing slot allocator.
// A key word is accepted at a clock edge where start is high and busy is low.
// The block probes slots (home + i*step) mod M, with home = key mod M and
// step = 1 + key mod (M-1), and marks the first free slot occupied.
// Each key gives exactly one result word: done is high for one cycle with
// slot and table_full valid. The receiver cannot stall; results are never
// held back or repeated.
// The two remainders come from two bit-serial units running side by side.
// Each probe is a read and a check of the occupancy memory. A key found on
// probe p (from 1) gives done at the end of that probe; a full table gives
// it after M probes.
// One key is in flight at a time; busy stays high until done.
// Reset clears the occupancy memory with a pass over all TABLE_DEPTH slots,
// one slot per cycle, during which busy is high. table_size resets to 251
// and may be written through cfg_we/cfg_wdata at any time the block is idle.
module double_hash_slot_allocator_unit #(
  parameter int TABLE_DEPTH = dhsa_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [dhsa_pkg::KEY_W-1:0]  key,
  output logic                        done,
  output logic [dhsa_pkg::SLOT_W-1:0] slot,
  output logic                        table_full,
  input  logic                        cfg_we,
  input  logic [dhsa_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int MW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (MW > dhsa_pkg::CFG_W) ? MW : dhsa_pkg::CFG_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_CHECK
  } state_t;

  state_t                     state;
  logic [dhsa_pkg::CFG_W-1:0] table_size;
  logic [AW-1:0]              clr_addr;
  logic [MW-1:0]              m;
  logic [MW-1:0]              h;
  logic [MW-1:0]              step;
  logic [MW-1:0]              probe;

  logic [CW-1:0]      ts_ext;
  logic [MW-1:0]      m_eff;
  logic               accept;
  logic               div0_done;
  logic               div1_done;
  logic [MW-1:0]      rem0;
  logic [MW-1:0]      rem1;
  logic [MW:0]        h_sum;
  logic [MW-1:0]      h_next;
  dhsa_pkg::mem_cmd_t mem_cmd;
  logic [AW-1:0]      mem_addr;
  logic               mem_rdata;

  // The configured size is clamped to the range the table supports.
  always_comb begin
    ts_ext = CW'(table_size);
    if (ts_ext < CW'(2)) begin
      m_eff = MW'(2);
    end else if (ts_ext > CW'(TABLE_DEPTH)) begin
      m_eff = MW'(TABLE_DEPTH);
    end else begin
      m_eff = ts_ext[MW-1:0];
    end
  end

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  dhsa_mod_unit #(.MW(MW)) u_mod_home (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (key),
    .divisor  (m_eff),
    .done     (div0_done),
    .rem      (rem0)
  );

  dhsa_mod_unit #(.MW(MW)) u_mod_step (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (key),
    .divisor  (m_eff - 1'b1),
    .done     (div1_done),
    .rem      (rem1)
  );

  // Both h and step are below M, so one conditional subtract wraps the sum.
  always_comb begin
    h_sum = {1'b0, h} + {1'b0, step};
    if (h_sum >= {1'b0, m}) begin
      h_next = MW'(h_sum - {1'b0, m});
    end else begin
      h_next = h_sum[MW-1:0];
    end
  end

  always_comb begin
    mem_cmd  = '0;
    mem_addr = h[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        mem_cmd.wr = 1'b1;
        mem_addr   = clr_addr;
      end
      S_READ: begin
        mem_cmd.rd = 1'b1;
      end
      S_CHECK: begin
        if (!mem_rdata) begin
          mem_cmd.wr    = 1'b1;
          mem_cmd.wdata = 1'b1;
        end
      end
      default: begin
        mem_cmd = '0;
      end
    endcase
  end

  dhsa_occ_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_occ_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= dhsa_pkg::TABLE_SIZE_RST;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            m     <= m_eff;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div0_done && div1_done) begin
            h     <= rem0;
            step  <= rem1 + 1'b1;
            probe <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!mem_rdata) begin
            done       <= 1'b1;
            slot       <= dhsa_pkg::SLOT_W'(h);
            table_full <= 1'b0;
            state      <= S_IDLE;
          end else if (probe == m - 1'b1) begin
            done       <= 1'b1;
            slot       <= '0;
            table_full <= 1'b1;
            state      <= S_IDLE;
          end else begin
            h     <= h_next;
            probe <= probe + 1'b1;
            state <= S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
